@@ hdl/trs_pkg.sv @@
// trs_pkg: constants, request codes and shared types for the time range selection table
// no dependencies; imported by trs_in_if, the cell and the top level
`default_nettype none

package trs_pkg;

  localparam int MAX_RANGES = 16;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int TIME_W     = 64;

  // request codes
  localparam logic [1:0] REQ_SELECT   = 2'd0;
  localparam logic [1:0] REQ_UNSELECT = 2'd1;
  localparam logic [1:0] REQ_CLEAR    = 2'd2;
  localparam logic [1:0] REQ_QUERY    = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;

  typedef logic [TIME_W-1:0] time_t;

  // request as broadcast to every cell, ends already in order
  typedef struct packed {
    logic [1:0] kind;
    time_t      lo;
    time_t      hi;
    time_t      t;
  } req_t;

  // signals passed from one cell to the next
  typedef struct packed {
    logic taken;
    logic hit;
  } chain_t;

endpackage

`default_nettype wire

@@ hdl/trs_in_if.sv @@
// trs_in_if: request channel of the time range selection table
// depends on trs_pkg
`default_nettype none

interface trs_in_if
  import trs_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  time_t      range_start;
  time_t      range_stop;
  time_t      probe_time;

  modport source (output valid, output req_type, output range_start,
                  output range_stop, output probe_time, input ready);
  modport sink   (input valid, input req_type, input range_start,
                  input range_stop, input probe_time, output ready);
endinterface

`default_nettype wire

@@ hdl/trs_out_if.sv @@
// trs_out_if: result channel of the time range selection table
// no dependencies
`default_nettype none

interface trs_out_if;
  logic       valid;
  logic       ready;
  logic       in_selection;
  logic       has_selection;
  logic       changed;
  logic [1:0] status;

  modport source (output valid, output in_selection, output has_selection,
                  output changed, output status, input ready);
  modport sink   (input valid, input in_selection, input has_selection,
                  input changed, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/trs_cell.sv @@
// trs_cell: one slot of the range table with its compare logic
// depends on trs_pkg; cells are chained through chain_t in the top level
`default_nettype none

module trs_cell
  import trs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   fire,
  input  wire req_t   req,
  input  wire chain_t chain_in,
  output chain_t      chain_out
);

  logic  valid_r, valid_nxt;
  time_t lo_r;
  time_t hi_r;
  logic  free;
  logic  match;
  logic  covers;
  logic  take_here;

  assign free   = !valid_r;
  assign match  = valid_r && (lo_r == req.lo) && (hi_r == req.hi);
  assign covers = valid_r && ($signed(req.t) >= $signed(lo_r)) &&
                  ($signed(req.t) <= $signed(hi_r));

  always_comb begin
    unique case (req.kind)
      REQ_SELECT:   take_here = free && !chain_in.taken;
      REQ_UNSELECT: take_here = match && !chain_in.taken;
      default:      take_here = 1'b0;
    endcase
  end

  assign chain_out.taken = chain_in.taken | take_here;
  assign chain_out.hit   = chain_in.hit | covers;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      unique case (req.kind)
        REQ_SELECT:   if (take_here) valid_nxt = 1'b1;
        REQ_UNSELECT: if (take_here) valid_nxt = 1'b0;
        REQ_CLEAR:    valid_nxt = 1'b0;
        default:      valid_nxt = valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // slot payload, written only when a select claims this cell
  always_ff @(posedge clk) begin
    if (fire && (req.kind == REQ_SELECT) && take_here) begin
      lo_r <= req.lo;
      hi_r <= req.hi;
    end
  end

endmodule

`default_nettype wire

@@ hdl/time_range_selection_table.sv @@
// time_range_selection_table: table of inclusive signed time ranges in a row of cells
// pipeline: the request is registered in the order stage, the result in the cell stage
// throughput: one request per cycle unless out_ch.ready stalls; every cell compares in
//   parallel, and the first-free / first-match claim ripples through the cell chain
// reset: synchronous active-low rst_n empties the table and drops pending results
// depends on trs_pkg, trs_in_if, trs_out_if, trs_cell
`default_nettype none

module time_range_selection_table
  import trs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch
);

  logic              s1_valid_r, s1_valid_nxt;
  req_t              s1_req_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_selection_r;
  logic              has_selection_r;
  logic              changed_r;
  logic [1:0]        status_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              adv2;
  logic              adv1;
  logic              fire;
  logic              swap;
  chain_t            chain [0:MAX_RANGES];

  logic              res_in_sel;
  logic              res_changed;
  logic [1:0]        res_status;

  assign adv2  = !out_valid_r || out_ch.ready;
  assign adv1  = !s1_valid_r || adv2;
  assign fire  = s1_valid_r && adv2;
  assign in_ch.ready = adv1;

  // order stage: put the range ends in order
  assign swap = $signed(in_ch.range_start) > $signed(in_ch.range_stop);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (adv1) s1_valid_nxt = in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_ch.valid) begin
      s1_req_r.kind <= in_ch.req_type;
      s1_req_r.lo   <= swap ? in_ch.range_stop : in_ch.range_start;
      s1_req_r.hi   <= swap ? in_ch.range_start : in_ch.range_stop;
      s1_req_r.t    <= in_ch.probe_time;
    end
  end

  // cell stage
  assign chain[0] = '{taken: 1'b0, hit: 1'b0};

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    trs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .fire      (fire),
      .req       (s1_req_r),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  always_comb begin
    count_nxt   = count_r;
    res_in_sel  = 1'b0;
    res_changed = 1'b0;
    res_status  = ST_OK;
    unique case (s1_req_r.kind)
      REQ_SELECT: begin
        res_changed = chain[MAX_RANGES].taken;
        res_status  = chain[MAX_RANGES].taken ? ST_OK : ST_FULL;
        if (chain[MAX_RANGES].taken) count_nxt = count_r + CNT_W'(1);
      end
      REQ_UNSELECT: begin
        res_changed = chain[MAX_RANGES].taken;
        res_status  = chain[MAX_RANGES].taken ? ST_OK : ST_NOMATCH;
        if (chain[MAX_RANGES].taken) count_nxt = count_r - CNT_W'(1);
      end
      REQ_CLEAR: begin
        res_changed = (count_r != '0);
        count_nxt   = '0;
      end
      REQ_QUERY: begin
        // an empty table matches every time
        res_in_sel = (count_r == '0) || chain[MAX_RANGES].hit;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv2) out_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      in_selection_r  <= res_in_sel;
      has_selection_r <= (count_nxt != '0);
      changed_r       <= res_changed;
      status_r        <= res_status;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.in_selection  = in_selection_r;
  assign out_ch.has_selection = has_selection_r;
  assign out_ch.changed       = changed_r;
  assign out_ch.status        = status_r;

endmodule

`default_nettype wire
